@@ src/fbb_pkg.sv @@
package fbb_pkg;

  // Largest rectangle side; wider or taller commands are clamped to it.
  localparam int MAX_DIM = 4096;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int COLOR_W = 24;
  localparam int ADDR_W  = 32;
  localparam int BYTE_W  = 8;

  // Linear pixel index of a rectangle origin: y * screen_width + x.
  localparam int LIN_W   = 26;
  // Three times a column index, and the screen row of the current line.
  localparam int COL3_W  = DIM_W + 1;
  localparam int SROW_W  = DIM_W + 1;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic KIND_RECT  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FB_BASE       = 2'd2;

  localparam logic [DIM_W-1:0]  SCREEN_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]  SCREEN_HEIGHT_RST = DIM_W'(480);
  localparam logic [ADDR_W-1:0] FB_BASE_RST       = '0;

endpackage

@@ src/fbb_in_if.sv @@
interface fbb_in_if
  import fbb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] rect_x;
  logic [COORD_W-1:0] rect_y;
  logic [DIM_W-1:0]   rect_w;
  logic [DIM_W-1:0]   rect_h;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, kind, rect_x, rect_y, rect_w, rect_h, pixel_color,
                  input ready);
  modport sink (input valid, kind, rect_x, rect_y, rect_w, rect_h, pixel_color,
                output ready);
endinterface

@@ src/fbb_out_if.sv @@
interface fbb_out_if
  import fbb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [BYTE_W-1:0] blue;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] red;

  modport source (output valid, write_address, blue, green, red, input ready);
  modport sink (input valid, write_address, blue, green, red, output ready);
endinterface

@@ src/framebuffer_rect_blit.sv @@
// A pixel request that writes passes through the input register, then the result register,
// and is taken from there by the output channel. Throughput: one request per cycle unless
// the output is stalled; the origin multiply sits before the input register and the row
// address advances by one add per line, so nothing loops.
// Reset (rst_n low, synchronous): no rectangle active, both channels empty,
// registers back to 640 x 480 with the framebuffer at address 0.
module framebuffer_rect_blit
  import fbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  fbb_in_if.sink             in_chan,
  fbb_out_if.source          out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Configuration registers.
  logic [DIM_W-1:0]  screen_width_r;
  logic [DIM_W-1:0]  screen_height_r;
  logic [ADDR_W-1:0] fb_base_r;

  // Input register.
  logic               in_vld_r;
  logic               in_kind_r;
  logic [COORD_W-1:0] in_x_r;
  logic [COORD_W-1:0] in_y_r;
  logic [DIM_W-1:0]   in_w_r;
  logic [DIM_W-1:0]   in_h_r;
  logic [COLOR_W-1:0] in_pix_r;
  logic [LIN_W-1:0]   in_lin_r;

  // Rectangle state.
  logic               active_r, active_nxt;
  logic [DIM_W-1:0]   span_w_r, span_w_nxt;
  logic [DIM_W-1:0]   span_h_r, span_h_nxt;
  logic [DIM_W-1:0]   clipped_len_r, clipped_len_nxt;
  logic [DIM_W-1:0]   col_cnt_r, col_cnt_nxt;
  logic [DIM_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic [COL3_W-1:0]  col3_r, col3_nxt;
  logic [SROW_W-1:0]  scr_row_r, scr_row_nxt;
  logic [ADDR_W-1:0]  row_addr_r, row_addr_nxt;

  // Result register.
  logic              out_vld_r, out_vld_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  logic [COLOR_W-1:0] out_pix_r;

  logic               advance;
  logic               in_take;
  logic               proc;
  logic               emit;
  logic [DIM_W-1:0]   w_clamp;
  logic [DIM_W-1:0]   h_clamp;
  logic [LIN_W-1:0]   lin_in;
  logic [DIM_W-1:0]   room;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;
  logic [COL3_W:0]    stride3;
  logic               cfg_wr;

  assign advance = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !in_vld_r || advance;
  assign in_take = in_chan.valid && in_chan.ready;
  assign proc = in_vld_r && advance;

  assign w_clamp = (in_chan.rect_w > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_chan.rect_w;
  assign h_clamp = (in_chan.rect_h > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_chan.rect_h;
  assign lin_in  = LIN_W'(in_chan.rect_y * screen_width_r) + LIN_W'(in_chan.rect_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
    if (in_take) begin
      in_kind_r <= in_chan.kind;
      in_x_r    <= in_chan.rect_x;
      in_y_r    <= in_chan.rect_y;
      in_w_r    <= w_clamp;
      in_h_r    <= h_clamp;
      in_pix_r  <= in_chan.pixel_color;
      in_lin_r  <= lin_in;
    end
  end

  assign room    = screen_width_r - DIM_W'(in_x_r);
  assign col_inc = col_cnt_r + DIM_W'(1);
  assign row_inc = row_cnt_r + DIM_W'(1);
  assign stride3 = (COL3_W + 1)'(screen_width_r) + (COL3_W + 1)'({screen_width_r, 1'b0});
  assign emit = proc && (in_kind_r == KIND_PIXEL) && active_r &&
                (col_cnt_r < clipped_len_r) && (scr_row_r < SROW_W'(screen_height_r));

  always_comb begin
    active_nxt      = active_r;
    span_w_nxt      = span_w_r;
    span_h_nxt      = span_h_r;
    clipped_len_nxt = clipped_len_r;
    col_cnt_nxt     = col_cnt_r;
    row_cnt_nxt     = row_cnt_r;
    col3_nxt        = col3_r;
    scr_row_nxt     = scr_row_r;
    row_addr_nxt    = row_addr_r;
    if (proc) begin
      if (in_kind_r == KIND_RECT) begin
        span_w_nxt = in_w_r;
        span_h_nxt = in_h_r;
        if (DIM_W'(in_x_r) >= screen_width_r) begin
          clipped_len_nxt = '0;
        end else if (in_w_r > room) begin
          clipped_len_nxt = room;
        end else begin
          clipped_len_nxt = in_w_r;
        end
        col_cnt_nxt  = '0;
        row_cnt_nxt  = '0;
        col3_nxt     = '0;
        scr_row_nxt  = SROW_W'(in_y_r);
        row_addr_nxt = fb_base_r + ADDR_W'(in_lin_r) + ADDR_W'({in_lin_r, 1'b0});
        active_nxt   = (in_w_r != '0) && (in_h_r != '0);
      end else if (active_r) begin
        if (col_inc >= span_w_r) begin
          col_cnt_nxt  = '0;
          col3_nxt     = '0;
          row_cnt_nxt  = row_inc;
          scr_row_nxt  = scr_row_r + SROW_W'(1);
          row_addr_nxt = row_addr_r + ADDR_W'(stride3);
          if (row_inc >= span_h_r) begin
            active_nxt = 1'b0;
          end
        end else begin
          col_cnt_nxt = col_inc;
          col3_nxt    = col3_r + COL3_W'(3);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      span_w_r      <= '0;
      span_h_r      <= '0;
      clipped_len_r <= '0;
      col_cnt_r     <= '0;
      row_cnt_r     <= '0;
      col3_r        <= '0;
      scr_row_r     <= '0;
      row_addr_r    <= '0;
    end else begin
      active_r      <= active_nxt;
      span_w_r      <= span_w_nxt;
      span_h_r      <= span_h_nxt;
      clipped_len_r <= clipped_len_nxt;
      col_cnt_r     <= col_cnt_nxt;
      row_cnt_r     <= row_cnt_nxt;
      col3_r        <= col3_nxt;
      scr_row_r     <= scr_row_nxt;
      row_addr_r    <= row_addr_nxt;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
    if (emit) begin
      out_addr_r <= row_addr_r + ADDR_W'(col3_r);
      out_pix_r  <= in_pix_r;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.write_address = out_addr_r;
  assign out_chan.blue          = out_pix_r[BYTE_W-1:0];
  assign out_chan.green         = out_pix_r[2*BYTE_W-1:BYTE_W];
  assign out_chan.red           = out_pix_r[3*BYTE_W-1:2*BYTE_W];

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
      fb_base_r       <= FB_BASE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SCREEN_WIDTH:  screen_width_r  <= pwdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= pwdata[DIM_W-1:0];
        REG_FB_BASE:       fb_base_r       <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SCREEN_WIDTH:  prdata = PDATA_W'(screen_width_r);
      REG_SCREEN_HEIGHT: prdata = PDATA_W'(screen_height_r);
      REG_FB_BASE:       prdata = PDATA_W'(fb_base_r);
      default:           prdata = '0;
    endcase
  end

  a_emit_only_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (in_vld_r && in_kind_r == KIND_PIXEL && active_r))
    else $error("write request produced outside an active rectangle");

  a_col_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (col_cnt_r < span_w_r && row_cnt_r < span_h_r))
    else $error("rectangle counters ran past the span");

  a_clip_le_span: assert property (@(posedge clk) disable iff (!rst_n)
    clipped_len_r <= span_w_r)
    else $error("clipped length exceeds rectangle width");

  a_col3_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    col3_r == COL3_W'(col_cnt_r) + COL3_W'({col_cnt_r, 1'b0}))
    else $error("column byte offset out of step with column count");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (in_vld_r && out_vld_r && !out_chan.ready))
    else $error("input stalled while the pipeline could move");

endmodule
